/* rtl/imhdk_pkg.sv */
// ----------------------------------------------------------------------------
// imhdk_pkg: shared types for the indexed min-heap
// Entry layout, command/status codes and the control/status bundles that
// join the sequencer and the datapath.
// ----------------------------------------------------------------------------
package imhdk_pkg;

   localparam int ID_W      = 10;
   localparam int COST_W    = 32;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 11;
   localparam int REQ_W     = 48;  // cmd | item_id | cost, byte padded
   localparam int RSP_W     = 24;  // status | popped_id | entry_count, byte padded

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE   = 2'd0,
      ST_REJECT = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_RSVD   = 2'd3
   } status_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [ID_W-1:0]   id;
   } entry_type;

   // heap read address source
   typedef enum logic [2:0] {
      RD_NONE,
      RD_SLOT,
      RD_ROOT,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   // datapath update for this cycle
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_REJECT,
      ACT_EMPTY,
      ACT_DEC,
      ACT_INS,
      ACT_POP_ROOT,
      ACT_POP_ONLY,
      ACT_POP_LAST,
      ACT_UP_MOVE,
      ACT_PLACE,
      ACT_CHILD_L,
      ACT_CHILD_PICK,
      ACT_DOWN_MOVE
   } act_type;

   typedef struct packed {
      logic       load;
      rd_sel_type rd_sel;
      act_type    act;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    count_one;
      logic    full;
      logic    id_bad;
      logic    present;
      logic    lower;
      logic    pos_zero;
      logic    up_swap;
      logic    left_in;
      logic    right_in;
      logic    down_swap;
      logic    out_free;
   } dp_stat_type;

endpackage

/* rtl/imhdk_ctrl.sv */
// ----------------------------------------------------------------------------
// imhdk_ctrl: command sequencer
// One-hot state machine that walks push/decrease, pop and clear through the
// datapath one memory access at a time.
// ----------------------------------------------------------------------------
module imhdk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  imhdk_pkg::dp_stat_type stat,
   output imhdk_pkg::ctrl_cmd_type cmd
);
   import imhdk_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DISPATCH = 13'b0000000000010,
      S_PU_SLOT  = 13'b0000000000100,
      S_PU_CHK   = 13'b0000000001000,
      S_PO_ROOT  = 13'b0000000010000,
      S_PO_LAST  = 13'b0000000100000,
      S_SU_ISSUE = 13'b0000001000000,
      S_SU_CMP   = 13'b0000010000000,
      S_SD_ISSUE = 13'b0000100000000,
      S_SD_L     = 13'b0001000000000,
      S_SD_R     = 13'b0010000000000,
      S_SD_CMP   = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.rd_sel = RD_NONE;
      cmd.act    = ACT_NONE;
      cmd.emit   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.cmd)
               CMD_PUSH: state_in = S_PU_SLOT;
               CMD_POP: begin
                  if (stat.count_zero) begin
                     cmd.act  = ACT_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     cmd.rd_sel = RD_ROOT;
                     state_in   = S_PO_ROOT;
                  end
               end
               CMD_CLEAR: begin
                  cmd.act  = ACT_CLEAR;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PU_SLOT: begin
            cmd.rd_sel = RD_SLOT;
            state_in   = S_PU_CHK;
         end
         S_PU_CHK: begin
            if (stat.id_bad || (stat.present && !stat.lower) ||
                (!stat.present && stat.full)) begin
               cmd.act  = ACT_REJECT;
               state_in = S_DONE;
            end else if (stat.present) begin
               cmd.act  = ACT_DEC;
               state_in = S_SU_ISSUE;
            end else begin
               cmd.act  = ACT_INS;
               state_in = S_SU_ISSUE;
            end
         end
         S_PO_ROOT: begin
            if (stat.count_one) begin
               cmd.act  = ACT_POP_ONLY;
               state_in = S_DONE;
            end else begin
               cmd.act    = ACT_POP_ROOT;
               cmd.rd_sel = RD_LAST;
               state_in   = S_PO_LAST;
            end
         end
         S_PO_LAST: begin
            cmd.act  = ACT_POP_LAST;
            state_in = S_SD_ISSUE;
         end
         S_SU_ISSUE: begin
            if (stat.pos_zero) begin
               cmd.act  = ACT_PLACE;
               state_in = S_DONE;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            if (stat.up_swap) begin
               cmd.act  = ACT_UP_MOVE;
               state_in = S_SU_ISSUE;
            end else begin
               cmd.act  = ACT_PLACE;
               state_in = S_DONE;
            end
         end
         S_SD_ISSUE: begin
            if (!stat.left_in) begin
               cmd.act  = ACT_PLACE;
               state_in = S_DONE;
            end else begin
               cmd.rd_sel = RD_LEFT;
               state_in   = S_SD_L;
            end
         end
         S_SD_L: begin
            cmd.act = ACT_CHILD_L;
            if (stat.right_in) begin
               cmd.rd_sel = RD_RIGHT;
               state_in   = S_SD_R;
            end else begin
               state_in = S_SD_CMP;
            end
         end
         S_SD_R: begin
            cmd.act  = ACT_CHILD_PICK;
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            if (stat.down_swap) begin
               cmd.act  = ACT_DOWN_MOVE;
               state_in = S_SD_ISSUE;
            end else begin
               cmd.act  = ACT_PLACE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/imhdk_dp.sv */
// ----------------------------------------------------------------------------
// imhdk_dp: heap datapath
// Heap store and id-to-slot map, request/result registers, the entry being
// sifted (hole method) and the compares that steer the sequencer.
// ----------------------------------------------------------------------------
module imhdk_dp #(
   parameter int CAPACITY = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [imhdk_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [imhdk_pkg::RSP_W-1:0]   rsp_tdata,
   input  imhdk_pkg::ctrl_cmd_type       cmd,
   output imhdk_pkg::dp_stat_type        stat
);
   import imhdk_pkg::*;

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IDS = 2 ** ID_W;

   // stores; the slot map is presence-checked against the heap, so it needs
   // no clearing
   entry_type   heap_mem [CAPACITY];
   bit [SW-1:0] slot_mem [IDS];

   cmd_type           cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [COST_W-1:0] cost_ff;
   logic [SW-1:0]     slot_rd_ff;
   entry_type         rd_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [SW-1:0]     pos_ff, pos_in;
   entry_type         mov_ff, mov_in;
   entry_type         child_ff, child_in;
   logic [SW-1:0]     cidx_ff, cidx_in;
   status_type        stat_ff, stat_in;
   logic [ID_W-1:0]   popped_ff, popped_in;
   logic              out_valid_ff;
   logic [RSP_W-1:0]  out_data_ff;

   logic [SW-1:0]   parent;
   logic [SW:0]     left;
   logic [SW+1:0]   right;
   logic [SW-1:0]   rd_addr;
   logic            hwe;
   entry_type       hwdata;
   logic [ID_W-1:0] swaddr;

   assign parent = SW'((pos_ff - SW'(1)) >> 1);
   assign left   = {pos_ff, 1'b1};
   assign right  = (SW+2)'(left) + (SW+2)'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_SLOT:   rd_addr = slot_rd_ff;
         RD_LAST:   rd_addr = SW'(count_ff - CW'(1));
         RD_PARENT: rd_addr = parent;
         RD_LEFT:   rd_addr = left[SW-1:0];
         RD_RIGHT:  rd_addr = right[SW-1:0];
         default:   rd_addr = '0;
      endcase
   end

   // status to the sequencer
   always_comb begin
      stat.cmd        = cmd_ff;
      stat.count_zero = (count_ff == '0);
      stat.count_one  = (count_ff == CW'(1));
      stat.full       = (count_ff == CW'(CAPACITY));
      stat.id_bad     = (32'(id_ff) >= 32'(CAPACITY));
      stat.present    = (CW'(slot_rd_ff) < count_ff) && (rd_ff.id == id_ff);
      stat.lower      = (rd_ff.cost > cost_ff);
      stat.pos_zero   = (pos_ff == '0);
      stat.up_swap    = (rd_ff.cost > mov_ff.cost);
      stat.left_in    = ((SW+1)'(count_ff) > left);
      stat.right_in   = ((SW+2)'(count_ff) > right);
      stat.down_swap  = (mov_ff.cost > child_ff.cost);
      stat.out_free   = !out_valid_ff || rsp_tready;
   end

   // register updates and store writes
   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      mov_in    = mov_ff;
      child_in  = child_ff;
      cidx_in   = cidx_ff;
      stat_in   = stat_ff;
      popped_in = popped_ff;
      hwe       = 1'b0;
      hwdata    = mov_ff;
      swaddr    = mov_ff.id;
      if (cmd.load) begin
         stat_in   = ST_DONE;
         popped_in = '0;
      end
      case (cmd.act)
         ACT_CLEAR:  count_in = '0;
         ACT_REJECT: stat_in = ST_REJECT;
         ACT_EMPTY:  stat_in = ST_EMPTY;
         ACT_DEC: begin
            mov_in = '{cost: cost_ff, id: id_ff};
            pos_in = slot_rd_ff;
         end
         ACT_INS: begin
            mov_in   = '{cost: cost_ff, id: id_ff};
            pos_in   = SW'(count_ff);
            count_in = count_ff + CW'(1);
         end
         ACT_POP_ROOT: popped_in = rd_ff.id;
         ACT_POP_ONLY: begin
            popped_in = rd_ff.id;
            count_in  = '0;
         end
         ACT_POP_LAST: begin
            mov_in   = rd_ff;
            count_in = count_ff - CW'(1);
            pos_in   = '0;
         end
         ACT_UP_MOVE: begin
            hwe    = 1'b1;
            hwdata = rd_ff;
            swaddr = rd_ff.id;
            pos_in = parent;
         end
         ACT_PLACE: hwe = 1'b1;
         ACT_CHILD_L: begin
            child_in = rd_ff;
            cidx_in  = left[SW-1:0];
         end
         ACT_CHILD_PICK: begin
            if (child_ff.cost > rd_ff.cost) begin
               child_in = rd_ff;
               cidx_in  = right[SW-1:0];
            end
         end
         ACT_DOWN_MOVE: begin
            hwe    = 1'b1;
            hwdata = child_ff;
            swaddr = child_ff.id;
            pos_in = cidx_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (hwe) begin
         heap_mem[pos_ff] <= hwdata;
         slot_mem[swaddr] <= pos_ff;
      end
      if (cmd.rd_sel != RD_NONE) begin
         rd_ff <= heap_mem[rd_addr];
      end
      slot_rd_ff <= slot_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= cmd_type'(req_tdata[CMD_W-1:0]);
         id_ff   <= req_tdata[CMD_W +: ID_W];
         cost_ff <= req_tdata[CMD_W+ID_W +: COST_W];
      end
      pos_ff    <= pos_in;
      mov_ff    <= mov_in;
      child_ff  <= child_in;
      cidx_ff   <= cidx_in;
      stat_ff   <= stat_in;
      popped_ff <= popped_in;
      if (cmd.emit) begin
         out_data_ff <= RSP_W'({CNT_OUT_W'(count_ff), popped_ff, stat_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* rtl/indexed_min_heap_decrease_key_top.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top: indexed binary min-heap with decrease-key
// Push (insert or lower cost), pop minimum and clear, one transaction at a
// time, one result transaction per command.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields, low bit first
//  --------+-----+---------------------------------------------------------
//  req_    | in  | cmd[1:0] item_id[11:2] cost[43:12] (Q24.8), zero pad
//  rsp_    | out | status[1:0] popped_id[11:2] entry_count[22:12], zero pad
//
//  Clear, nop and an empty pop need no heap read. Push reads its own slot,
//  then climbs with one parent read per level; pop reads the root and, with
//  more than one entry, the last entry, then descends reading up to two
//  children per level.
//  The heap store has one read and one write port; each level costs one
//  registered read per entry examined.
//  Reset is synchronous and empties the heap; no clearing pass is needed.
//  A finished result waits in an output register; the next command is
//  accepted meanwhile and holds only at its own finish until rsp_ drains.
//
module indexed_min_heap_decrease_key_top #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [imhdk_pkg::REQ_W-1:0] req_tdata,  // cmd, item_id, cost
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [imhdk_pkg::RSP_W-1:0] rsp_tdata   // status, popped_id, entry_count
);
   import imhdk_pkg::*;

   ctrl_cmd_type ctl;
   dp_stat_type  dps;

   // sequencer: one memory access per state
   imhdk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dps),
      .cmd        (ctl)
   );

   // stores, sift registers and output register
   imhdk_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (ctl),
      .stat       (dps)
   );

endmodule

/* rtl/imhdk_checker.sv */
// ----------------------------------------------------------------------------
// imhdk_checker: port-level checks for the heap block
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module imhdk_checker #(
   parameter int CAPACITY = 1024
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [imhdk_pkg::RSP_W-1:0] rsp_tdata
);
   import imhdk_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != ST_RSVD)
      else $error("reserved status code");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_EMPTY |->
         rsp_tdata[11:2] == '0 && rsp_tdata[22:12] == '0)
      else $error("empty pop reports an id or a nonzero count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 2047) || (32'(rsp_tdata[22:12]) <= 32'(CAPACITY)))
      else $error("entry count beyond capacity");

endmodule

bind indexed_min_heap_decrease_key_top imhdk_checker #(
   .CAPACITY (CAPACITY)
) u_imhdk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/indexed_min_heap_decrease_key_top_tb.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top_tb: self-checking bench for the min-heap
// Drives push, pop, clear and unused commands through req_, predicts every
// response with a behavioral heap and compares rsp_ field by field.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import imhdk_pkg::*;

   localparam int CAP       = 1024;
   localparam int RAND_CNT  = 450;
   localparam int CYC_LIMIT = 400000;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   id;
      logic [COST_W-1:0] cost;
   } heap_cmd_type;

   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      popped;
      logic [CNT_OUT_W-1:0] count;
   } heap_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   indexed_min_heap_decrease_key_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // cmd, item_id, cost
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // status, popped_id, entry_count
   );

   always #10 clock = ~clock;

   // shadow heap state
   logic [ID_W-1:0]   sh_id   [CAP];
   logic [COST_W-1:0] sh_cost [CAP];
   int unsigned       sh_slot [CAP];
   int unsigned       sh_count;

   heap_cmd_type   cmd_queue[$];
   heap_rsp_type   rsp_expected[$];
   int unsigned err_count;
   int unsigned cycle_count;
   bit          stim_done;
   bit          quiet;        // no idling in the tail of the run
   int unsigned req_hold, rsp_hold;

   function automatic void heap_swap(int unsigned a, int unsigned b);
      logic [ID_W-1:0]   ti;
      logic [COST_W-1:0] tc;
      ti = sh_id[a]; tc = sh_cost[a];
      sh_slot[sh_id[a]] = b;
      sh_slot[sh_id[b]] = a;
      sh_id[a] = sh_id[b]; sh_cost[a] = sh_cost[b];
      sh_id[b] = ti;       sh_cost[b] = tc;
   endfunction

   function automatic void climb(int unsigned p);
      int unsigned par;
      while (p != 0) begin
         par = (p - 1) / 2;
         if (!(sh_cost[par] > sh_cost[p])) break;
         heap_swap(par, p);
         p = par;
      end
   endfunction

   function automatic void descend(int unsigned p);
      int unsigned l, nx;
      forever begin
         l = 2 * p + 1;
         if (l >= sh_count) break;
         if (l + 1 >= sh_count) nx = l;
         else nx = (sh_cost[l] > sh_cost[l+1]) ? l + 1 : l;
         if (!(sh_cost[p] > sh_cost[nx])) break;
         heap_swap(nx, p);
         p = nx;
      end
   endfunction

   // predicted response for one accepted command; updates shadow state
   function automatic heap_rsp_type heap_apply(heap_cmd_type c);
      heap_rsp_type r;
      int unsigned  s;
      r = '{status: ST_DONE, popped: '0, count: '0};
      case (c.cmd)
         CMD_PUSH: begin
            if (sh_slot[c.id] < sh_count) begin
               s = sh_slot[c.id];
               if (sh_cost[s] > c.cost) begin
                  sh_cost[s] = c.cost;
                  climb(s);
               end else r.status = ST_REJECT;
            end else if (sh_count >= CAP) begin
               r.status = ST_REJECT;
            end else begin
               s = sh_count;
               sh_id[s] = c.id; sh_cost[s] = c.cost; sh_slot[c.id] = s;
               sh_count = s + 1;
               climb(s);
            end
         end
         CMD_POP: begin
            if (sh_count == 0) r.status = ST_EMPTY;
            else begin
               r.popped = sh_id[0];
               heap_swap(0, sh_count - 1);
               sh_slot[sh_id[sh_count-1]] = CAP;
               sh_count = sh_count - 1;
               descend(0);
            end
         end
         CMD_CLEAR: begin
            foreach (sh_slot[i]) sh_slot[i] = CAP;
            sh_count = 0;
         end
         default: ;
      endcase
      r.count = sh_count[CNT_OUT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
      err_count++;
   endtask

   function automatic void add_cmd(cmd_type k, int unsigned id, logic [31:0] cost);
      heap_cmd_type c;
      c.cmd = k; c.id = id[ID_W-1:0]; c.cost = cost;
      cmd_queue.push_back(c);
   endfunction

   // driver: one transaction per handshake, random idle bursts
   always @(posedge clock) begin
      heap_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold   <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold current transaction
      end else if (req_hold != 0) begin
         req_tvalid <= 1'b0;
         req_hold   <= req_hold - 1;
      end else if (cmd_queue.size() != 0) begin
         c = cmd_queue.pop_front();
         req_tdata  <= {4'b0, c.cost, c.id, c.cmd};
         req_tvalid <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) req_hold <= $urandom_range(1, 10);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // predictor fed at the accepting edge
   always @(posedge clock) begin
      heap_cmd_type c;
      if (!reset && req_tvalid && req_tready) begin
         c.cmd  = cmd_type'(req_tdata[1:0]);
         c.id   = req_tdata[11:2];
         c.cost = req_tdata[43:12];
         rsp_expected.push_back(heap_apply(c));
      end
   end

   // monitor and response back-pressure
   always @(posedge clock) begin
      heap_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               report_mismatch("response with nothing pending", 32'(rsp_tdata), 0);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
               if (rsp_tdata[11:2] != want.popped)
                  report_mismatch("popped_id", 32'(rsp_tdata[11:2]), 32'(want.popped));
               if (rsp_tdata[22:12] != want.count)
                  report_mismatch("entry_count", 32'(rsp_tdata[22:12]), 32'(want.count));
            end
         end
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_hold - 1;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(0, 9);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYC_LIMIT) begin
         $display("indexed_min_heap_decrease_key_top verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned pick, id, pool;
      logic [31:0] cst;
      err_count = 0; cycle_count = 0; stim_done = 0; quiet = 0;
      sh_count = 0;
      foreach (sh_slot[i]) sh_slot[i] = CAP;
      // directed: empty pop, extremes, decrease, equal/higher reject, nop, clear
      add_cmd(CMD_POP, 0, 0);
      add_cmd(CMD_PUSH, 1023, 32'hFFFF_FFFF);
      add_cmd(CMD_PUSH, 0, 32'h0000_0000);
      add_cmd(CMD_PUSH, 512, 32'h8000_0100);
      add_cmd(CMD_PUSH, 341, 32'h5555_5555);
      add_cmd(CMD_PUSH, 682, 32'hAAAA_AAAA);
      add_cmd(CMD_PUSH, 682, 32'hAAAA_AAAA);     // equal cost: reject
      add_cmd(CMD_PUSH, 341, 32'h6000_0000);     // higher cost: reject
      add_cmd(CMD_PUSH, 1023, 32'h0000_0001);    // decrease to near top
      add_cmd(CMD_PUSH, 7, 32'h5555_5555);       // equal cost to a peer
      add_cmd(CMD_NOP, 1023, 32'hFFFF_FFFF);
      for (int k = 0; k < 7; k++) add_cmd(CMD_POP, 0, 0);
      add_cmd(CMD_PUSH, 3, 32'h100);
      add_cmd(CMD_PUSH, 4, 32'h200);
      add_cmd(CMD_CLEAR, 1023, 32'hFFFF_FFFF);
      add_cmd(CMD_POP, 0, 0);
      add_cmd(CMD_PUSH, 4, 32'h50);              // id re-pushed after clear
      // random: small id pool mostly, so decreases and rejects occur
      for (int n = 0; n < RAND_CNT; n++) begin
         pool = ($urandom_range(0, 3) == 0) ? 1023 : 31;
         id   = $urandom_range(0, pool);
         cst  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 64);
         pick = $urandom_range(0, 99);
         if (pick < 55)      add_cmd(CMD_PUSH, id, cst);
         else if (pick < 94) add_cmd(CMD_POP, $urandom_range(0, 1023), $urandom());
         else if (pick < 97) add_cmd(CMD_CLEAR, id, cst);
         else                add_cmd(CMD_NOP, id, cst);
         if (n == RAND_CNT * 4 / 5) quiet = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (cmd_queue.size() < 60);
      quiet = 1'b1;
      wait (cmd_queue.size() == 0 && !req_tvalid && rsp_expected.size() == 0);
      repeat (60) @(posedge clock);
      if (err_count == 0 && rsp_expected.size() == 0)
         $display("indexed_min_heap_decrease_key_top verification clean");
      else
         $display("indexed_min_heap_decrease_key_top verification failed");
      $finish;
   end

endmodule

/* indexed_min_heap_decrease_key_top.f */
rtl/imhdk_pkg.sv
rtl/imhdk_ctrl.sv
rtl/imhdk_dp.sv
rtl/indexed_min_heap_decrease_key_top.sv
rtl/imhdk_checker.sv
sim/indexed_min_heap_decrease_key_top_tb.sv
